// File: hdl/rfae_pkg.sv
`timescale 1ns / 1ps
package rfae_pkg;

   localparam int NUM_REGS    = 8;
   localparam int REG_AW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int IDX_W       = 3;
   localparam int DATA_W      = 32;
   localparam int SHAMT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = 5;
   localparam int RSP_DATA_W  = 40;

   typedef enum logic [3:0] {
      OPC_ADD = 4'd0,
      OPC_AND = 4'd1,
      OPC_TST = 4'd2,
      OPC_ASR = 4'd3,
      OPC_LSR = 4'd4,
      OPC_LSL = 4'd5,
      OPC_NOT = 4'd6,
      OPC_ORR = 4'd7,
      OPC_SUB = 4'd8,
      OPC_CMP = 4'd9,
      OPC_XOR = 4'd10,
      OPC_MOV = 4'd11
   } op_code_type;

   typedef enum logic [3:0] {
      FN_NONE,
      FN_ADD,
      FN_AND,
      FN_ASR,
      FN_LSR,
      FN_LSL,
      FN_NOT,
      FN_ORR,
      FN_SUB,
      FN_XOR,
      FN_MOV
   } alu_fn_type;

   typedef struct packed {
      alu_fn_type          fn;
      logic                writes;
      logic                flags_en;
      logic [IDX_W-1:0]    dest;
      logic [IDX_W-1:0]    src_a;
      logic [IDX_W-1:0]    src_b;
      logic [DATA_W-1:0]   imm;
   } item_type;

endpackage

// File: hdl/rfae_front.sv
`timescale 1ns / 1ps
module rfae_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rfae_pkg::REQ_DATA_W-1:0]  req_tdata,  // dest_index, source_a_index, source_b_index, immediate
   input  logic [rfae_pkg::REQ_USER_W-1:0]  req_tuser,  // operation, set_flags
   input  logic                             q_full,
   output logic                             q_push,
   output rfae_pkg::item_type               q_item
);
   import rfae_pkg::*;

   op_code_type opc;
   logic        sflag;
   logic        dest_ok;

   assign opc        = op_code_type'(req_tuser[3:0]);
   assign sflag      = req_tuser[4];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign dest_ok    = int'(req_tdata[2:0]) < NUM_REGS;

   always_comb begin
      q_item.dest  = req_tdata[2:0];
      q_item.src_a = req_tdata[5:3];
      q_item.src_b = req_tdata[8:6];
      q_item.imm   = req_tdata[40:9];
      q_item.fn       = FN_NONE;
      q_item.writes   = 1'b0;
      q_item.flags_en = 1'b0;
      unique case (opc)
         OPC_ADD: begin q_item.fn = FN_ADD; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_AND: begin q_item.fn = FN_AND; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_TST: begin q_item.fn = FN_AND; q_item.flags_en = 1'b1; end
         OPC_ASR: begin q_item.fn = FN_ASR; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_LSR: begin q_item.fn = FN_LSR; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_LSL: begin q_item.fn = FN_LSL; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_NOT: begin q_item.fn = FN_NOT; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_ORR: begin q_item.fn = FN_ORR; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_SUB: begin q_item.fn = FN_SUB; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_CMP: begin q_item.fn = FN_SUB; q_item.flags_en = 1'b1; end
         OPC_XOR: begin q_item.fn = FN_XOR; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         OPC_MOV: begin q_item.fn = FN_MOV; q_item.writes = dest_ok; q_item.flags_en = sflag; end
         default: begin q_item.fn = FN_NONE; end
      endcase
   end

endmodule

// File: hdl/rfae_queue.sv
`timescale 1ns / 1ps
module rfae_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfae_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output rfae_pkg::item_type head_item
);
   import rfae_pkg::*;

   item_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// File: hdl/rfae_back.sv
`timescale 1ns / 1ps
module rfae_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  rfae_pkg::item_type               q_item,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rfae_pkg::RSP_DATA_W-1:0]  rsp_tdata   // result_value, register_written, negative_flag, zero_flag
);
   import rfae_pkg::*;

   logic [DATA_W-1:0]   rf_ff [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;

   logic                ex_valid_ff, ex_valid_in;
   item_type            ex_item_ff;
   logic [DATA_W-1:0]   ex_a_ff, ex_b_ff;

   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_res_ff;
   logic                out_wr_ff, out_n_ff, out_z_ff;

   logic                n_ff, n_in;
   logic                z_ff, z_in;

   logic                adv;
   logic                fire;
   logic                wr_en;
   logic [REG_AW-1:0]   wr_addr, a_addr, b_addr;
   logic                a_ok, b_ok;
   logic [SHAMT_W-1:0]  shamt;
   logic [DATA_W-1:0]   res;

   assign adv     = !out_valid_ff || rsp_tready;
   assign fire    = adv && ex_valid_ff;
   assign q_pop   = adv && q_valid;
   assign wr_en   = fire && ex_item_ff.writes;
   assign wr_addr = REG_AW'(ex_item_ff.dest);
   assign a_addr  = REG_AW'(q_item.src_a);
   assign b_addr  = REG_AW'(q_item.src_b);
   assign a_ok    = int'(q_item.src_a) < NUM_REGS;
   assign b_ok    = int'(q_item.src_b) < NUM_REGS;
   assign shamt   = ex_item_ff.imm[SHAMT_W-1:0];

   always_comb begin
      unique case (ex_item_ff.fn)
         FN_ADD:  res = ex_a_ff + ex_b_ff;
         FN_AND:  res = ex_a_ff & ex_b_ff;
         FN_ASR:  res = $unsigned($signed(ex_a_ff) >>> shamt);
         FN_LSR:  res = ex_a_ff >> shamt;
         FN_LSL:  res = ex_a_ff << shamt;
         FN_NOT:  res = ~ex_a_ff;
         FN_ORR:  res = ex_a_ff | ex_b_ff;
         FN_SUB:  res = ex_a_ff - ex_b_ff;
         FN_XOR:  res = ex_a_ff ^ ex_b_ff;
         FN_MOV:  res = ex_item_ff.imm;
         default: res = '0;
      endcase
   end

   always_comb begin
      n_in         = ex_item_ff.flags_en ? res[DATA_W-1] : n_ff;
      z_in         = ex_item_ff.flags_en ? (res == '0) : z_ff;
      ex_valid_in  = adv ? q_valid : ex_valid_ff;
      out_valid_in = adv ? ex_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         n_ff         <= 1'b0;
         z_ff         <= 1'b0;
         rf_vld_ff    <= '0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            n_ff <= n_in;
            z_ff <= z_in;
         end
         if (wr_en) begin
            rf_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // register file, write-first toward the operand read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_ff[wr_addr] <= res;
      end
      if (q_pop) begin
         ex_item_ff <= q_item;
         priority if (!a_ok) begin
            ex_a_ff <= '0;
         end else if (wr_en && wr_addr == a_addr) begin
            ex_a_ff <= res;
         end else if (!rf_vld_ff[a_addr]) begin
            ex_a_ff <= '0;
         end else begin
            ex_a_ff <= rf_ff[a_addr];
         end
         priority if (!b_ok) begin
            ex_b_ff <= '0;
         end else if (wr_en && wr_addr == b_addr) begin
            ex_b_ff <= res;
         end else if (!rf_vld_ff[b_addr]) begin
            ex_b_ff <= '0;
         end else begin
            ex_b_ff <= rf_ff[b_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_res_ff <= res;
         out_wr_ff  <= ex_item_ff.writes;
         out_n_ff   <= n_in;
         out_z_ff   <= z_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - 3){1'b0}}, out_z_ff, out_n_ff, out_wr_ff,
                        out_res_ff};

   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rf_vld_ff[$past(wr_addr)])
      else $error("written register not marked valid");
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && !ex_item_ff.flags_en) |=> ($stable(n_ff) && $stable(z_ff)))
      else $error("flags changed without update enable");
   a_out_flags: assert property (@(posedge clock) disable iff (reset)
      fire |=> (out_n_ff == n_ff && out_z_ff == z_ff && out_valid_ff))
      else $error("reported flags differ from flag state");
   a_pop_feeds_ex: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> ex_valid_ff)
      else $error("popped word lost before execute");

endmodule

// File: hdl/register_file_alu_executor.sv
`timescale 1ns / 1ps
// Executes one decoded ALU instruction per word against eight 32-bit registers with N and Z
// flags, one result word per request word. A request is decoded on entry and parked in a
// two-entry queue; the back end reads both source registers as the word leaves the queue,
// computes and writes back from the registered operands and holds the result in an output register.
// Sustained rate is one word per clock while results are taken; a result passes through the
// queue entry, the registered register-file read and the output register before it is valid.
// A result stall fills the queue and then drops req_tready.
module register_file_alu_executor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rfae_pkg::REQ_DATA_W-1:0]  req_tdata,  // dest_index, source_a_index, source_b_index, immediate
   input  logic [rfae_pkg::REQ_USER_W-1:0]  req_tuser,  // operation, set_flags
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rfae_pkg::RSP_DATA_W-1:0]  rsp_tdata   // result_value, register_written, negative_flag, zero_flag
);
   import rfae_pkg::*;

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type push_item;
   item_type head_item;

   rfae_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   rfae_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   rfae_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: sim/register_file_alu_executor_checker.sv
`timescale 1ns / 1ps
module register_file_alu_executor_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rfae_pkg::REQ_DATA_W-1:0]  req_tdata,  // dest_index, source_a_index, source_b_index, immediate
   input  logic [rfae_pkg::REQ_USER_W-1:0]  req_tuser,  // operation, set_flags
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rfae_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // result_value, register_written, negative_flag, zero_flag
   output int                               fail_count,
   output int                               outstanding
);
   import rfae_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              written;
      logic              negative;
      logic              zero;
   } alu_result_type;

   logic [DATA_W-1:0] shadow_regs [NUM_REGS];
   logic              shadow_n;
   logic              shadow_z;
   alu_result_type    expected_results [$];
   alu_result_type    want;
   int                mismatches = 0;
   int                i;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] exp_val);
      $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, exp_val);
      mismatches++;
   endtask

   function automatic logic [DATA_W-1:0] read_shadow(input logic [IDX_W-1:0] idx);
      if (idx < NUM_REGS) return shadow_regs[idx];
      return '0;
   endfunction

   function automatic alu_result_type execute_instruction(input logic [REQ_DATA_W-1:0] data,
                                                          input logic [REQ_USER_W-1:0] user);
      logic [3:0]        op;
      logic              s;
      logic [IDX_W-1:0]  d;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] imm;
      logic [4:0]        sh;
      logic [DATA_W-1:0] res;
      logic              known;
      logic              writes;
      logic              always_flags;
      alu_result_type    r;
      op           = user[3:0];
      s            = user[4];
      d            = data[2:0];
      a            = read_shadow(data[5:3]);
      b            = read_shadow(data[8:6]);
      imm          = data[40:9];
      sh           = imm[4:0];
      res          = '0;
      known        = 1'b1;
      writes       = 1'b1;
      always_flags = 1'b0;
      case (op)
         OPC_ADD: res = a + b;
         OPC_AND: res = a & b;
         OPC_TST: begin
            res = a & b;
            writes = 1'b0;
            always_flags = 1'b1;
         end
         OPC_ASR: res = $unsigned($signed(a) >>> sh);
         OPC_LSR: res = a >> sh;
         OPC_LSL: res = a << sh;
         OPC_NOT: res = ~a;
         OPC_ORR: res = a | b;
         OPC_SUB: res = a - b;
         OPC_CMP: begin
            res = a - b;
            writes = 1'b0;
            always_flags = 1'b1;
         end
         OPC_XOR: res = a ^ b;
         OPC_MOV: res = imm;
         default: begin
            known = 1'b0;
            writes = 1'b0;
         end
      endcase
      r.written = 1'b0;
      if (writes && d < NUM_REGS) begin
         shadow_regs[d] = res;
         r.written = 1'b1;
      end
      if (known && (s || always_flags)) begin
         shadow_n = res[DATA_W-1];
         shadow_z = (res == '0);
      end
      r.value    = res;
      r.negative = shadow_n;
      r.zero     = shadow_z;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;
         shadow_n = 1'b0;
         shadow_z = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("result_value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[32] !== want.written)
                  report_mismatch("register_written", DATA_W'(rsp_tdata[32]),
                                  DATA_W'(want.written));
               if (rsp_tdata[33] !== want.negative)
                  report_mismatch("negative_flag", DATA_W'(rsp_tdata[33]),
                                  DATA_W'(want.negative));
               if (rsp_tdata[34] !== want.zero)
                  report_mismatch("zero_flag", DATA_W'(rsp_tdata[34]), DATA_W'(want.zero));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(execute_instruction(req_tdata, req_tuser));
      end
      outstanding <= expected_results.size();
   end

endmodule

// File: sim/register_file_alu_executor_test.sv
`timescale 1ns / 1ps
module register_file_alu_executor_test;
   import rfae_pkg::*;

   localparam logic [3:0] OPC_UNUSED_LO = 4'd12;
   localparam logic [3:0] OPC_UNUSED_HI = 4'd15;
   localparam int         RANDOM_ITEMS  = 900;
   localparam int         LONG_STALL_AT = 300;
   localparam int         LONG_STALL    = 250;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    outstanding;
   int                    words_sent = 0;
   logic                  sender_fast = 1'b0;

   always #10 clock = ~clock;

   register_file_alu_executor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   register_file_alu_executor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   task automatic send_word(input logic [3:0] op, input logic s, input logic [2:0] d,
                            input logic [2:0] a, input logic [2:0] b,
                            input logic [31:0] imm);
      int unsigned gap;
      gap = sender_fast ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, imm, b, a, d};
      req_tuser  <= {s, op};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_random();
      logic [3:0]  op;
      logic [31:0] imm;
      if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(OPC_UNUSED_LO, OPC_UNUSED_HI));
      else op = 4'($urandom_range(OPC_ADD, OPC_MOV));
      case ($urandom_range(0, 7))
         0:       imm = '0;
         1:       imm = '1;
         2:       imm = 32'h8000_0000 | $urandom_range(0, 255);
         3:       imm = $urandom_range(0, 31);
         default: imm = $urandom;
      endcase
      send_word(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), imm);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (outstanding != 0);
   endtask

   // result side: random stalls, one long hold-off to back up the queue
   initial begin
      int unsigned stall;
      int          results_seen;
      logic        taker_fast;
      results_seen = 0;
      taker_fast   = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (results_seen % 40 == 0) taker_fast = ($urandom_range(0, 3) == 0);
         stall = taker_fast ? 0 : $urandom_range(0, 18);
         if (results_seen == LONG_STALL_AT) stall = LONG_STALL;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         results_seen++;
      end
   end

   initial begin
      #5_000_000;
      $display("[register_file_alu_executor] ERROR");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, unused codes
      send_word(OPC_MOV, 1'b1, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF);
      send_word(OPC_MOV, 1'b0, 3'd1, 3'd5, 3'd6, 32'h8000_0000);
      send_word(OPC_MOV, 1'b1, 3'd2, 3'd7, 3'd7, 32'h0000_0001);
      send_word(OPC_MOV, 1'b1, 3'd3, 3'd0, 3'd0, 32'h0000_0000);
      send_word(OPC_ADD, 1'b1, 3'd4, 3'd0, 3'd2, 32'h0);
      send_word(OPC_ADD, 1'b0, 3'd5, 3'd1, 3'd1, 32'h0);
      send_word(OPC_AND, 1'b1, 3'd6, 3'd0, 3'd1, 32'h0);
      send_word(OPC_TST, 1'b0, 3'd7, 3'd0, 3'd3, 32'h0);
      send_word(OPC_ASR, 1'b1, 3'd7, 3'd1, 3'd0, 32'h0000_001F);
      send_word(OPC_ASR, 1'b0, 3'd7, 3'd2, 3'd0, 32'hFFFF_FFE0);
      send_word(OPC_LSR, 1'b1, 3'd6, 3'd0, 3'd0, 32'h0000_001F);
      send_word(OPC_LSL, 1'b1, 3'd6, 3'd2, 3'd0, 32'hFFFF_FFFF);
      send_word(OPC_NOT, 1'b1, 3'd5, 3'd3, 3'd0, 32'h0);
      send_word(OPC_ORR, 1'b0, 3'd4, 3'd1, 3'd2, 32'h0);
      send_word(OPC_SUB, 1'b1, 3'd4, 3'd3, 3'd2, 32'h0);
      send_word(OPC_CMP, 1'b0, 3'd0, 3'd2, 3'd2, 32'h0);
      send_word(OPC_CMP, 1'b1, 3'd1, 3'd3, 3'd2, 32'h0);
      send_word(OPC_XOR, 1'b1, 3'd0, 3'd0, 3'd0, 32'h0);
      send_word(OPC_UNUSED_LO, 1'b1, 3'd1, 3'd0, 3'd0, 32'h0);
      send_word(OPC_UNUSED_HI, 1'b1, 3'd2, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_word(OPC_MOV, 1'b1, 3'd7, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_word(OPC_SUB, 1'b1, 3'd7, 3'd7, 3'd1, 32'h0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) sender_fast = ($urandom_range(0, 3) == 0);
         // keep offering while the result side is held off
         if (n >= 270 && n < 360) sender_fast = 1'b1;
         if (n == 600) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         send_random();
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[register_file_alu_executor] OK");
      end else begin
         $display("[register_file_alu_executor] ERROR");
      end
      $finish;
   end

endmodule
